// ===== design/mfm_pkg.sv =====
// Shared types, widths and codes for the maze flood-map engine.
// Used by mfm_bank, mfm_core and maze_flood_map_engine; depends on nothing.
package mfm_pkg;

   localparam int COORD_W = 4;
   localparam int VAL_W = 9;
   localparam int LINK_W = 4;
   localparam int HEAD_W = 2;
   localparam int MODE_W = 3;
   localparam int CSR_W = 4;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;
   localparam int VAL_MAX = 511;

   localparam int MAZE_SIDE_DEF = 16;
   localparam int NO_NEIGHBOR_DEF = 255;

   typedef enum logic [MODE_W-1:0] {
      MODE_SET_WALL     = 3'd0,
      MODE_MARK_VISITED = 3'd1,
      MODE_FLOOD_UPDATE = 3'd2,
      MODE_CHOOSE_DIR   = 3'd3,
      MODE_SET_VALUE    = 3'd4
   } mode_type;

   typedef enum logic [HEAD_W-1:0] {
      DIR_NORTH = 2'd0,
      DIR_EAST  = 2'd1,
      DIR_SOUTH = 2'd2,
      DIR_WEST  = 2'd3
   } dir_type;

   typedef enum logic [0:0] {
      CSR_START_ROW = 1'b0,
      CSR_START_COL = 1'b1
   } csr_type;

   typedef struct packed {
      logic                visited;
      logic [LINK_W-1:0]   links;
      logic [VAL_W-1:0]    value;
   } cell_type;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [COORD_W-1:0]  row;
      logic [COORD_W-1:0]  col;
      logic [HEAD_W-1:0]   heading;
      logic                refill;
      logic [VAL_W-1:0]    new_value;
   } item_type;

   typedef struct packed {
      logic [HEAD_W-1:0]   chosen_heading;
      logic                value_changed;
      logic [3:0]          push_mask;
      logic [VAL_W-1:0]    cell_value;
      logic [VAL_W-1:0]    least_neighbor;
   } result_type;

   typedef struct packed {
      logic                en;
      cell_type            word;
   } write_type;

endpackage

// ===== design/mfm_bank.sv =====
// One bank of the cell map: one write port and two registered read ports.
// Depends on mfm_pkg for the cell word type.
module mfm_bank #(
   parameter int AW = 6
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  mfm_pkg::cell_type  wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr0,
   input  logic [AW-1:0]      rd_addr1,
   output mfm_pkg::cell_type  rd_data0,
   output mfm_pkg::cell_type  rd_data1
);

   mfm_pkg::cell_type mem_ff [2**AW];
   mfm_pkg::cell_type rd0_ff;
   mfm_pkg::cell_type rd1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd0_ff <= mem_ff[rd_addr0];
         rd1_ff <= mem_ff[rd_addr1];
      end
   end

   assign rd_data0 = rd0_ff;
   assign rd_data1 = rd1_ff;

endmodule

// ===== design/mfm_core.sv =====
// Operation logic for one request: wall, visited, flood update, direction choice, value set.
// Works on the addressed cell and its four neighbors; depends on mfm_pkg.
module mfm_core #(
   parameter int MAZE_SIDE = mfm_pkg::MAZE_SIDE_DEF,
   parameter int NO_NEIGHBOR_VALUE = mfm_pkg::NO_NEIGHBOR_DEF
) (
   input  mfm_pkg::item_type               item,
   input  mfm_pkg::cell_type               center,
   input  mfm_pkg::cell_type [3:0]         nb,
   input  logic [mfm_pkg::COORD_W-1:0]     start_row,
   input  logic [mfm_pkg::COORD_W-1:0]     start_col,
   output mfm_pkg::result_type             result,
   output mfm_pkg::write_type              wr
);

   localparam int CW = mfm_pkg::COORD_W;
   localparam int VW = mfm_pkg::VAL_W;
   localparam int NW = $clog2(NO_NEIGHBOR_VALUE + 1);
   localparam int LW = (NW > VW) ? NW : VW;
   localparam int EW = ($clog2(MAZE_SIDE + 1) > CW + 1) ? $clog2(MAZE_SIDE + 1) : CW + 1;
   localparam logic [EW-1:0] SIDE = EW'(MAZE_SIDE);
   localparam logic [EW-1:0] HALF = EW'(MAZE_SIDE / 2);
   localparam logic [LW:0] SAT = (LW + 1)'(mfm_pkg::VAL_MAX);

   logic [EW-1:0]          row_e;
   logic [EW-1:0]          col_e;
   logic                   in_maze;
   logic [3:0]             exists;
   logic [3:0]             link_out;
   logic [3:0]             open;
   logic [3:0]             qual;
   logic [3:0]             qual_unv;
   logic [mfm_pkg::LINK_W-1:0] new_links;
   logic [LW-1:0]          cand [4];
   logic [LW-1:0]          min_a;
   logic [LW-1:0]          min_b;
   logic [LW-1:0]          least;
   logic [LW:0]            least_p1;
   logic [VW-1:0]          least_sat;
   logic [VW-1:0]          flood_sat;
   logic                   prot;
   logic                   fits;
   logic                   flood_do;
   logic [1:0]             chosen;
   mfm_pkg::cell_type      new_center;

   always_comb begin
      row_e = EW'(item.row);
      col_e = EW'(item.col);
      in_maze = (row_e < SIDE) && (col_e < SIDE);
      exists[mfm_pkg::DIR_NORTH] = (row_e != '0);
      exists[mfm_pkg::DIR_EAST] = ((col_e + EW'(1)) < SIDE);
      exists[mfm_pkg::DIR_SOUTH] = ((row_e + EW'(1)) < SIDE);
      exists[mfm_pkg::DIR_WEST] = (col_e != '0);

      new_links = center.links;
      if (item.mode == mfm_pkg::MODE_SET_WALL) begin
         new_links[item.heading] = 1'b0;
      end

      for (int d = 0; d < 4; d++) begin
         link_out[d] = new_links[d] && exists[d];
         open[d] = link_out[d] && nb[d].links[(d + 2) % 4];
         cand[d] = open[d] ? LW'(nb[d].value) : LW'(NO_NEIGHBOR_VALUE);
      end
      min_a = (cand[0] < cand[1]) ? cand[0] : cand[1];
      min_b = (cand[2] < cand[3]) ? cand[2] : cand[3];
      least = (min_a < min_b) ? min_a : min_b;

      least_p1 = (LW + 1)'(least) + (LW + 1)'(1);
      least_sat = ((LW + 1)'(least) > SAT) ? VW'(mfm_pkg::VAL_MAX) : VW'(least);
      flood_sat = (least_p1 > SAT) ? VW'(mfm_pkg::VAL_MAX) : VW'(least_p1);
      fits = (least_p1 == (LW + 1)'(center.value));

      if (item.refill) begin
         prot = (item.row == start_row) && (item.col == start_col);
      end else begin
         prot = ((row_e == HALF) || (row_e + EW'(1) == HALF)) &&
                ((col_e == HALF) || (col_e + EW'(1) == HALF));
      end
      flood_do = (item.mode == mfm_pkg::MODE_FLOOD_UPDATE) && !prot && !fits;

      for (int d = 0; d < 4; d++) begin
         qual[d] = link_out[d] && (LW'(nb[d].value) == least);
         qual_unv[d] = qual[d] && !nb[d].visited;
      end
      if (qual[item.heading]) begin
         chosen = item.heading;
      end else if (qual_unv[0]) begin
         chosen = mfm_pkg::DIR_NORTH;
      end else if (qual_unv[1]) begin
         chosen = mfm_pkg::DIR_EAST;
      end else if (qual_unv[2]) begin
         chosen = mfm_pkg::DIR_SOUTH;
      end else if (qual_unv[3]) begin
         chosen = mfm_pkg::DIR_WEST;
      end else if (qual[0]) begin
         chosen = mfm_pkg::DIR_NORTH;
      end else if (qual[1]) begin
         chosen = mfm_pkg::DIR_EAST;
      end else if (qual[2]) begin
         chosen = mfm_pkg::DIR_SOUTH;
      end else begin
         chosen = mfm_pkg::DIR_WEST;
      end

      new_center = center;
      wr.en = 1'b0;
      case (item.mode)
         mfm_pkg::MODE_SET_WALL: begin
            new_center.links = new_links;
            wr.en = in_maze;
         end
         mfm_pkg::MODE_MARK_VISITED: begin
            new_center.visited = 1'b1;
            wr.en = in_maze;
         end
         mfm_pkg::MODE_FLOOD_UPDATE: begin
            if (flood_do) begin
               new_center.value = flood_sat;
            end
            wr.en = in_maze && flood_do;
         end
         mfm_pkg::MODE_SET_VALUE: begin
            new_center.value = item.new_value;
            wr.en = in_maze;
         end
         default: begin
            wr.en = 1'b0;
         end
      endcase
      wr.word = new_center;

      result = '0;
      if (in_maze) begin
         result.chosen_heading = (item.mode == mfm_pkg::MODE_CHOOSE_DIR) ? chosen : 2'd0;
         result.value_changed = flood_do;
         result.push_mask = flood_do ?
            {open[mfm_pkg::DIR_SOUTH], open[mfm_pkg::DIR_NORTH],
             open[mfm_pkg::DIR_EAST], open[mfm_pkg::DIR_WEST]} : 4'd0;
         result.cell_value = new_center.value;
         result.least_neighbor = least_sat;
      end
   end

endmodule

// ===== design/maze_flood_map_engine.sv =====
// Maze flood-map engine: an accepted request is held in the working stage, then registered as the response.
// One request per cycle is sustained while responses are taken; each map bank has one write port and two
// read ports, and the last write is forwarded into the next request's reads.
// Reset is synchronous; a clearing pass then loads the map,
// with req_tready low and csr writes taken.
module maze_flood_map_engine #(
   parameter int MAZE_SIDE = mfm_pkg::MAZE_SIDE_DEF,
   parameter int NO_NEIGHBOR_VALUE = mfm_pkg::NO_NEIGHBOR_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: cell_row[3:0], cell_col[7:4], heading[9:8], refill_to_start[10],
   // new_value[19:11], zero[23:20]
   input  logic [mfm_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: mode[2:0]
   input  logic [mfm_pkg::MODE_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: chosen_heading[1:0], value_changed[2], push_mask[6:3],
   // cell_value[15:7], least_neighbor[24:16], zero[31:25]
   output logic [mfm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_we,
   input  logic [0:0]                        csr_index,
   input  logic [mfm_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int CW = mfm_pkg::COORD_W;
   localparam int VW = mfm_pkg::VAL_W;
   localparam int HALF = (MAZE_SIDE + 1) / 2;
   localparam int HBITS = $clog2(HALF);
   localparam int AW = 2 * HBITS;
   localparam logic [AW-1:0] LAST_ADDR = '1;
   localparam logic [HBITS:0] HC = (HBITS + 1)'(MAZE_SIDE / 2);
   localparam logic [HBITS:0] LAST_RC = (HBITS + 1)'(MAZE_SIDE - 1);
   localparam logic [HBITS:0] ONE = (HBITS + 1)'(1);

   function automatic mfm_pkg::cell_type cell_reset(input logic [HBITS:0] r,
                                                    input logic [HBITS:0] c);
      logic [HBITS:0] dr;
      logic [HBITS:0] dc;
      mfm_pkg::cell_type w;
      dr = (r < HC) ? (HC - r - ONE) : (r - HC);
      dc = (c < HC) ? (HC - c - ONE) : (c - HC);
      w.visited = 1'b0;
      w.links[mfm_pkg::DIR_NORTH] = (r != '0);
      w.links[mfm_pkg::DIR_EAST] = (c != LAST_RC);
      w.links[mfm_pkg::DIR_SOUTH] = (r != LAST_RC);
      w.links[mfm_pkg::DIR_WEST] = (c != '0);
      w.value = VW'(dr) + VW'(dc);
      return w;
   endfunction

   logic                       clr_act_ff, clr_act_in;
   logic [AW-1:0]              clr_addr_ff, clr_addr_in;
   logic                       st_vld_ff, st_vld_in;
   logic                       rsp_vld_ff, rsp_vld_in;
   mfm_pkg::item_type          item_ff;
   mfm_pkg::result_type        rsp_res_ff;
   mfm_pkg::cell_type          fwd_word_ff;
   logic                       hit_c_ff, hit_c_in;
   logic [3:0]                 hit_nb_ff, hit_nb_in;
   logic [CW-1:0]              start_row_ff;
   logic [CW-1:0]              start_col_ff;

   mfm_pkg::item_type          item_in;
   logic                       accept;
   logic                       adv;
   logic                       wr_fire;

   logic [CW-1:0]              r_a, c_a;
   logic [CW:0]                rn_a, rs_a, ce_a, cw_a;
   logic [AW-1:0]              addr_c_a;
   logic [AW-1:0]              addr_a [4];
   logic [1:0]                 cb_a, nsb_a, ewb_a;
   logic [1:0]                 bank_a [4];

   logic [1:0]                 cb_s, nsb_s, ewb_s;
   logic [AW-1:0]              wr_addr;
   mfm_pkg::cell_type          bank_rd0 [4];
   mfm_pkg::cell_type          bank_rd1 [4];
   mfm_pkg::cell_type          raw_nb [4];
   mfm_pkg::cell_type          cen;
   mfm_pkg::cell_type [3:0]    nbs;
   mfm_pkg::result_type        core_res;
   mfm_pkg::write_type         core_wr;

   always_comb begin
      item_in.mode = req_tuser;
      item_in.row = req_tdata[3:0];
      item_in.col = req_tdata[7:4];
      item_in.heading = req_tdata[9:8];
      item_in.refill = req_tdata[10];
      item_in.new_value = req_tdata[19:11];
   end

   assign adv = st_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !clr_act_ff && (!st_vld_ff || adv);
   assign accept = req_tvalid && req_tready;
   assign wr_fire = adv && core_wr.en;

   // Addresses of the addressed cell and its neighbors for the incoming request.
   always_comb begin
      r_a = item_in.row;
      c_a = item_in.col;
      rn_a = {1'b0, r_a} - (CW + 1)'(1);
      rs_a = {1'b0, r_a} + (CW + 1)'(1);
      cw_a = {1'b0, c_a} - (CW + 1)'(1);
      ce_a = {1'b0, c_a} + (CW + 1)'(1);
      addr_c_a = {HBITS'(r_a[CW-1:1]), HBITS'(c_a[CW-1:1])};
      addr_a[mfm_pkg::DIR_NORTH] = {HBITS'(rn_a[CW:1]), HBITS'(c_a[CW-1:1])};
      addr_a[mfm_pkg::DIR_SOUTH] = {HBITS'(rs_a[CW:1]), HBITS'(c_a[CW-1:1])};
      addr_a[mfm_pkg::DIR_EAST] = {HBITS'(r_a[CW-1:1]), HBITS'(ce_a[CW:1])};
      addr_a[mfm_pkg::DIR_WEST] = {HBITS'(r_a[CW-1:1]), HBITS'(cw_a[CW:1])};
      cb_a = {r_a[0], c_a[0]};
      nsb_a = {~r_a[0], c_a[0]};
      ewb_a = {r_a[0], ~c_a[0]};
      bank_a[mfm_pkg::DIR_NORTH] = nsb_a;
      bank_a[mfm_pkg::DIR_SOUTH] = nsb_a;
      bank_a[mfm_pkg::DIR_EAST] = ewb_a;
      bank_a[mfm_pkg::DIR_WEST] = ewb_a;
   end

   // The write at the accepting edge is not yet visible to that edge's reads.
   always_comb begin
      hit_c_in = wr_fire && (cb_a == cb_s) && (addr_c_a == wr_addr);
      for (int d = 0; d < 4; d++) begin
         hit_nb_in[d] = wr_fire && (bank_a[d] == cb_s) && (addr_a[d] == wr_addr);
      end
   end

   genvar b;
   generate
      for (b = 0; b < 4; b++) begin : g_bank
         localparam logic [1:0] BID = 2'(b);
         logic                 we;
         logic [AW-1:0]        waddr;
         mfm_pkg::cell_type    wdata;
         logic [AW-1:0]        ra0;
         logic [AW-1:0]        ra1;

         always_comb begin
            if (clr_act_ff) begin
               we = 1'b1;
               waddr = clr_addr_ff;
               wdata = cell_reset({clr_addr_ff[AW-1:HBITS], BID[1]},
                                  {clr_addr_ff[HBITS-1:0], BID[0]});
            end else begin
               we = wr_fire && (cb_s == BID);
               waddr = wr_addr;
               wdata = core_wr.word;
            end
            if (BID == cb_a) begin
               ra0 = addr_c_a;
            end else if (BID == nsb_a) begin
               ra0 = addr_a[mfm_pkg::DIR_NORTH];
            end else begin
               ra0 = addr_a[mfm_pkg::DIR_EAST];
            end
            ra1 = (BID == nsb_a) ? addr_a[mfm_pkg::DIR_SOUTH] : addr_a[mfm_pkg::DIR_WEST];
         end

         mfm_bank #(
            .AW(AW)
         ) u_bank (
            .clock(clock),
            .wr_en(we),
            .wr_addr(waddr),
            .wr_data(wdata),
            .rd_en(accept),
            .rd_addr0(ra0),
            .rd_addr1(ra1),
            .rd_data0(bank_rd0[b]),
            .rd_data1(bank_rd1[b])
         );
      end
   endgenerate

   always_comb begin
      cb_s = {item_ff.row[0], item_ff.col[0]};
      nsb_s = {~item_ff.row[0], item_ff.col[0]};
      ewb_s = {item_ff.row[0], ~item_ff.col[0]};
      wr_addr = {HBITS'(item_ff.row[CW-1:1]), HBITS'(item_ff.col[CW-1:1])};
      raw_nb[mfm_pkg::DIR_NORTH] = bank_rd0[nsb_s];
      raw_nb[mfm_pkg::DIR_SOUTH] = bank_rd1[nsb_s];
      raw_nb[mfm_pkg::DIR_EAST] = bank_rd0[ewb_s];
      raw_nb[mfm_pkg::DIR_WEST] = bank_rd1[ewb_s];
      cen = hit_c_ff ? fwd_word_ff : bank_rd0[cb_s];
      for (int d = 0; d < 4; d++) begin
         nbs[d] = hit_nb_ff[d] ? fwd_word_ff : raw_nb[d];
      end
   end

   mfm_core #(
      .MAZE_SIDE(MAZE_SIDE),
      .NO_NEIGHBOR_VALUE(NO_NEIGHBOR_VALUE)
   ) u_core (
      .item(item_ff),
      .center(cen),
      .nb(nbs),
      .start_row(start_row_ff),
      .start_col(start_col_ff),
      .result(core_res),
      .wr(core_wr)
   );

   always_comb begin
      clr_act_in = clr_act_ff && (clr_addr_ff != LAST_ADDR);
      clr_addr_in = clr_act_ff ? clr_addr_ff + AW'(1) : clr_addr_ff;
      if (accept) begin
         st_vld_in = 1'b1;
      end else if (adv) begin
         st_vld_in = 1'b0;
      end else begin
         st_vld_in = st_vld_ff;
      end
      if (adv) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_act_ff <= 1'b1;
         clr_addr_ff <= '0;
         st_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         start_row_ff <= '0;
         start_col_ff <= '0;
      end else begin
         clr_act_ff <= clr_act_in;
         clr_addr_ff <= clr_addr_in;
         st_vld_ff <= st_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_we && (csr_index == mfm_pkg::CSR_START_ROW)) begin
            start_row_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == mfm_pkg::CSR_START_COL)) begin
            start_col_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
         hit_c_ff <= hit_c_in;
         hit_nb_ff <= hit_nb_in;
         fwd_word_ff <= core_wr.word;
      end
      if (adv) begin
         rsp_res_ff <= core_res;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata = {7'd0, rsp_res_ff.least_neighbor, rsp_res_ff.cell_value,
                       rsp_res_ff.push_mask, rsp_res_ff.value_changed,
                       rsp_res_ff.chosen_heading};

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_act_ff |-> !req_tready)
      else $error("Request accepted during the clearing pass.");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> st_vld_ff)
      else $error("Accepted request did not reach the working stage.");

   a_stalled_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (st_vld_ff && !adv) |=> (st_vld_ff && $stable(item_ff)))
      else $error("Stalled request was lost or changed.");

   a_no_write_in_clear: assert property (@(posedge clock) disable iff (reset)
      wr_fire |-> !clr_act_ff)
      else $error("Map write from a request during the clearing pass.");

   a_adv_gives_result: assert property (@(posedge clock) disable iff (reset)
      adv |=> rsp_vld_ff)
      else $error("Finished request did not produce a response.");

endmodule

// ===== dv/tb_maze_flood_map_engine.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for maze_flood_map_engine: a directed table, then random
// flood-fill cascades, each response checked against its table entry or an in-bench map predictor.
// Depends on mfm_pkg and the maze_flood_map_engine top level.
module tb_maze_flood_map_engine;
   import mfm_pkg::*;

   localparam int SIDE = MAZE_SIDE_DEF;
   localparam int CELLS = SIDE * SIDE;
   localparam int NO_NEIGHBOR = NO_NEIGHBOR_DEF;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES = 80;
   localparam int RANDOM_PER_PHASE = 500;
   localparam int WORK_LIST_MAX = 48;
   localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
   localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;
   localparam int MASK_WEST = 0;
   localparam int MASK_EAST = 1;
   localparam int MASK_NORTH = 2;
   localparam int MASK_SOUTH = 3;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [HEAD_W-1:0]  heading;
      logic               refill;
      logic [VAL_W-1:0]   new_value;
   } request_t;

   typedef struct {
      request_t   q;
      bit         typed;
      result_type want;
   } plan_row_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [MODE_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [0:0]            csr_index = '0;
   logic [CSR_W-1:0]      csr_wdata = '0;

   logic [VAL_W-1:0]   map_value [CELLS];
   logic [LINK_W-1:0]  map_links [CELLS];
   logic               map_visited [CELLS];
   logic [COORD_W-1:0] start_row_cfg;
   logic [COORD_W-1:0] start_col_cfg;

   result_type pending_results [$];
   plan_row_t  directed_plan [$];
   int         fail_count = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         hold_asks = 0;

   maze_flood_map_engine u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic void map_reset_state();
      int h, dr, dc, i;
      h = SIDE / 2;
      for (int r = 0; r < SIDE; r++) begin
         for (int c = 0; c < SIDE; c++) begin
            i = r * SIDE + c;
            dr = (r < h) ? h - 1 - r : r - h;
            dc = (c < h) ? h - 1 - c : c - h;
            map_value[i] = VAL_W'(dr + dc);
            map_links[i] = '1;
            if (r == 0) map_links[i][DIR_NORTH] = 1'b0;
            if (r == SIDE - 1) map_links[i][DIR_SOUTH] = 1'b0;
            if (c == 0) map_links[i][DIR_WEST] = 1'b0;
            if (c == SIDE - 1) map_links[i][DIR_EAST] = 1'b0;
            map_visited[i] = 1'b0;
         end
      end
      start_row_cfg = '0;
      start_col_cfg = '0;
   endfunction

   function automatic bit step_to(int r, int c, int d, output int idx);
      int nr, nc;
      nr = r;
      nc = c;
      idx = 0;
      case (dir_type'(d))
         DIR_NORTH: begin
            if (r == 0) return 1'b0;
            nr = r - 1;
         end
         DIR_EAST: begin
            if (c + 1 >= SIDE) return 1'b0;
            nc = c + 1;
         end
         DIR_SOUTH: begin
            if (r + 1 >= SIDE) return 1'b0;
            nr = r + 1;
         end
         default: begin
            if (c == 0) return 1'b0;
            nc = c - 1;
         end
      endcase
      idx = nr * SIDE + nc;
      return 1'b1;
   endfunction

   function automatic bit link_out(int r, int c, int d, output int idx);
      idx = 0;
      if (!map_links[r * SIDE + c][d]) return 1'b0;
      return step_to(r, c, d, idx);
   endfunction

   function automatic bit open_both(int r, int c, int d);
      int idx;
      if (!link_out(r, c, d, idx)) return 1'b0;
      return map_links[idx][(d + 2) % 4];
   endfunction

   function automatic int least_open(int r, int c);
      int best, idx;
      best = NO_NEIGHBOR;
      for (int d = 0; d < 4; d++) begin
         if (open_both(r, c, d)) begin
            void'(step_to(r, c, d, idx));
            if (map_value[idx] < best) best = map_value[idx];
         end
      end
      return best;
   endfunction

   function automatic bit heading_fits(int r, int c, int d, int least, bit need_unvisited);
      int idx;
      if (!link_out(r, c, d, idx)) return 1'b0;
      if (map_value[idx] != least) return 1'b0;
      return !need_unvisited || !map_visited[idx];
   endfunction

   function automatic result_type flood_map_step(request_t q);
      result_type res;
      int r, c, i, h, least;
      bit guarded, found;
      res = '0;
      r = q.row;
      c = q.col;
      i = r * SIDE + c;
      h = SIDE / 2;
      case (q.mode)
         MODE_SET_WALL: map_links[i][q.heading] = 1'b0;
         MODE_MARK_VISITED: map_visited[i] = 1'b1;
         MODE_FLOOD_UPDATE: begin
            if (q.refill) guarded = (q.row == start_row_cfg) && (q.col == start_col_cfg);
            else guarded = (r == h || r == h - 1) && (c == h || c == h - 1);
            if (!guarded) begin
               least = least_open(r, c);
               if (least + 1 != map_value[i]) begin
                  map_value[i] = VAL_W'((least + 1 > VAL_MAX) ? VAL_MAX : least + 1);
                  res.value_changed = 1'b1;
                  res.push_mask[MASK_WEST] = open_both(r, c, DIR_WEST);
                  res.push_mask[MASK_EAST] = open_both(r, c, DIR_EAST);
                  res.push_mask[MASK_NORTH] = open_both(r, c, DIR_NORTH);
                  res.push_mask[MASK_SOUTH] = open_both(r, c, DIR_SOUTH);
               end
            end
         end
         MODE_CHOOSE_DIR: begin
            least = least_open(r, c);
            if (heading_fits(r, c, q.heading, least, 1'b0)) begin
               res.chosen_heading = q.heading;
            end else begin
               res.chosen_heading = DIR_WEST;
               found = 1'b0;
               for (int d = 0; d < 4 && !found; d++) begin
                  if (heading_fits(r, c, d, least, 1'b1)) begin
                     res.chosen_heading = HEAD_W'(d);
                     found = 1'b1;
                  end
               end
               for (int d = 0; d < 3 && !found; d++) begin
                  if (heading_fits(r, c, d, least, 1'b0)) begin
                     res.chosen_heading = HEAD_W'(d);
                     found = 1'b1;
                  end
               end
            end
         end
         MODE_SET_VALUE: map_value[i] = q.new_value;
         default: ;
      endcase
      res.cell_value = map_value[i];
      least = least_open(r, c);
      res.least_neighbor = VAL_W'((least > VAL_MAX) ? VAL_MAX : least);
      return res;
   endfunction

   function automatic void plan_row(logic [MODE_W-1:0] mode, int row, int col, int heading,
                                    bit refill, int nv, bit typed, int ch, int chg, int mask,
                                    int cv, int ln);
      plan_row_t p;
      p.q.mode = mode;
      p.q.row = COORD_W'(row);
      p.q.col = COORD_W'(col);
      p.q.heading = HEAD_W'(heading);
      p.q.refill = refill;
      p.q.new_value = VAL_W'(nv);
      p.typed = typed;
      p.want.chosen_heading = HEAD_W'(ch);
      p.want.value_changed = chg[0];
      p.want.push_mask = 4'(mask);
      p.want.cell_value = VAL_W'(cv);
      p.want.least_neighbor = VAL_W'(ln);
      directed_plan.push_back(p);
   endfunction

   function automatic void compare_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic send_request(input request_t q, input bit typed, input result_type want,
                               output result_type predicted);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= q.mode;
      req_tdata <= {4'b0, q.new_value, q.refill, q.heading, q.col, q.row};
      do @(posedge clock); while (!req_tready);
      predicted = flood_map_step(q);
      pending_results.push_back(typed ? want : predicted);
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_start_cell(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col);
      csr_we <= 1'b1;
      csr_index <= CSR_START_ROW;
      csr_wdata <= row;
      @(posedge clock);
      start_row_cfg = row;
      csr_index <= CSR_START_COL;
      csr_wdata <= col;
      @(posedge clock);
      start_col_cfg = col;
      csr_we <= 1'b0;
   endtask

   // While cells are pending, most traffic follows the external stack loop: updated cells push their open
   // neighbors, which are then updated in turn. The rest mostly wanders around a cursor.
   task automatic run_flood_traffic(input int count);
      request_t   q;
      result_type got;
      int         work_r [$];
      int         work_c [$];
      int         cur_r, cur_c, pick, sent;
      bit         refill_now;
      cur_r = $urandom_range(SIDE - 1);
      cur_c = $urandom_range(SIDE - 1);
      refill_now = 1'b0;
      sent = 0;
      while (sent < count) begin
         q = '0;
         q.heading = HEAD_W'($urandom_range(3));
         q.refill = refill_now;
         q.new_value = VAL_W'($urandom_range(VAL_MAX));
         if (work_r.size() != 0 && $urandom_range(99) < 75) begin
            q.mode = MODE_FLOOD_UPDATE;
            q.row = COORD_W'(work_r.pop_back());
            q.col = COORD_W'(work_c.pop_back());
         end else begin
            work_r.delete();
            work_c.delete();
            refill_now = $urandom_range(1);
            q.refill = refill_now;
            cur_r = cur_r + $urandom_range(2) - 1;
            cur_c = cur_c + $urandom_range(2) - 1;
            cur_r = (cur_r < 0) ? 0 : (cur_r >= SIDE) ? SIDE - 1 : cur_r;
            cur_c = (cur_c < 0) ? 0 : (cur_c >= SIDE) ? SIDE - 1 : cur_c;
            pick = $urandom_range(99);
            if (pick < 70) begin
               q.row = COORD_W'(cur_r);
               q.col = COORD_W'(cur_c);
            end else if (pick < 75) begin
               q.row = start_row_cfg;
               q.col = start_col_cfg;
            end else begin
               q.row = COORD_W'($urandom_range(SIDE - 1));
               q.col = COORD_W'($urandom_range(SIDE - 1));
            end
            pick = $urandom_range(99);
            if (pick < 7) q.mode = MODE_SET_WALL;
            else if (pick < 19) q.mode = MODE_MARK_VISITED;
            else if (pick < 52) q.mode = MODE_FLOOD_UPDATE;
            else if (pick < 77) q.mode = MODE_CHOOSE_DIR;
            else if (pick < 95) q.mode = MODE_SET_VALUE;
            else q.mode = MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
            if (q.mode == MODE_SET_VALUE && $urandom_range(99) < 75)
               q.new_value = VAL_W'($urandom_range(40));
         end
         send_request(q, 1'b0, '0, got);
         sent++;
         if (q.mode == MODE_FLOOD_UPDATE && got.value_changed
             && work_r.size() < WORK_LIST_MAX) begin
            if (got.push_mask[MASK_WEST]) begin
               work_r.push_back(q.row);
               work_c.push_back(int'(q.col) - 1);
            end
            if (got.push_mask[MASK_EAST]) begin
               work_r.push_back(q.row);
               work_c.push_back(int'(q.col) + 1);
            end
            if (got.push_mask[MASK_NORTH]) begin
               work_r.push_back(int'(q.row) - 1);
               work_c.push_back(q.col);
            end
            if (got.push_mask[MASK_SOUTH]) begin
               work_r.push_back(int'(q.row) + 1);
               work_c.push_back(q.col);
            end
         end
      end
   endtask

   initial begin : response_side
      result_type got, want;
      int hold_left, hold_seen;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got.chosen_heading = rsp_tdata[1:0];
            got.value_changed = rsp_tdata[2];
            got.push_mask = rsp_tdata[6:3];
            got.cell_value = rsp_tdata[15:7];
            got.least_neighbor = rsp_tdata[24:16];
            if (pending_results.size() == 0) begin
               $error("Response arrived with no request pending: tdata %h", rsp_tdata);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               compare_field("chosen_heading", want.chosen_heading, got.chosen_heading);
               compare_field("value_changed", want.value_changed, got.value_changed);
               compare_field("push_mask", want.push_mask, got.push_mask);
               compare_field("cell_value", want.cell_value, got.cell_value);
               compare_field("least_neighbor", want.least_neighbor, got.least_neighbor);
            end
         end
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("maze_flood_map_engine verification failed");
      $finish;
   end

   initial begin : stimulus
      result_type predicted;
      map_reset_state();
      send_idle_pct = 20;
      recv_idle_pct = 80;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      set_start_cell(4'd0, 4'd0);

      plan_row(MODE_CHOOSE_DIR,    0,  0, DIR_NORTH, 0,   0, 1, 1, 0,  0,  14,  13);
      plan_row(MODE_FLOOD_UPDATE,  7,  7, DIR_NORTH, 0,   0, 1, 0, 0,  0,   0,   0);
      plan_row(MODE_FLOOD_UPDATE,  0,  0, DIR_NORTH, 1,   0, 1, 0, 0,  0,  14,  13);
      plan_row(MODE_FLOOD_UPDATE,  7,  7, DIR_NORTH, 1,   0, 1, 0, 1, 15,   1,   0);
      plan_row(MODE_FLOOD_UPDATE, 15, 15, DIR_NORTH, 0,   0, 1, 0, 0,  0,  14,  13);
      plan_row(MODE_SET_VALUE,    15, 15, DIR_NORTH, 0, 511, 1, 0, 0,  0, 511,  13);
      plan_row(MODE_FLOOD_UPDATE, 15, 15, DIR_SOUTH, 0,   0, 1, 0, 1,  5,  14,  13);
      plan_row(MODE_SET_WALL,      0,  0, DIR_NORTH, 0,   0, 1, 0, 0,  0,  14,  13);
      plan_row(MODE_SET_WALL,      2,  2, DIR_NORTH, 0,   0, 0, 0, 0,  0,   0,   0);
      plan_row(MODE_SET_WALL,      2,  2, DIR_EAST,  0,   0, 0, 0, 0,  0,   0,   0);
      plan_row(MODE_SET_WALL,      2,  2, DIR_SOUTH, 0,   0, 0, 0, 0,  0,   0,   0);
      plan_row(MODE_SET_WALL,      2,  2, DIR_WEST,  0,   0, 0, 0, 0,  0,   0,   0);
      plan_row(MODE_CHOOSE_DIR,    2,  2, DIR_EAST,  0,   0, 1, 3, 0,  0,  10, NO_NEIGHBOR);
      plan_row(MODE_FLOOD_UPDATE,  2,  2, DIR_WEST,  0,   0, 1, 0, 1,  0, 256, NO_NEIGHBOR);
      plan_row(MODE_SET_VALUE,     3,  4, DIR_NORTH, 0,   0, 1, 0, 0,  0,   0,   6);
      plan_row(MODE_UNUSED_LO,     3,  4, DIR_NORTH, 0,   0, 1, 0, 0,  0,   0,   6);
      plan_row(MODE_UNUSED_HI,     3,  4, DIR_WEST,  1, 511, 1, 0, 0,  0,   0,   6);
      plan_row(MODE_MARK_VISITED,  0,  1, DIR_NORTH, 0,   0, 1, 0, 0,  0,  13,  12);
      plan_row(MODE_CHOOSE_DIR,    0,  0, DIR_SOUTH, 0,   0, 1, 2, 0,  0,  14,  13);
      plan_row(MODE_CHOOSE_DIR,    0,  0, DIR_WEST,  0,   0, 0, 0, 0,  0,   0,   0);
      plan_row(MODE_MARK_VISITED,  1,  0, DIR_NORTH, 0,   0, 0, 0, 0,  0,   0,   0);
      plan_row(MODE_CHOOSE_DIR,    0,  0, DIR_WEST,  0,   0, 0, 0, 0,  0,   0,   0);
      plan_row(MODE_SET_WALL,      5,  5, DIR_EAST,  0,   0, 0, 0, 0,  0,   0,   0);
      plan_row(MODE_CHOOSE_DIR,    5,  6, DIR_WEST,  0,   0, 0, 0, 0,  0,   0,   0);
      plan_row(MODE_FLOOD_UPDATE,  5,  5, DIR_EAST,  1, 256, 0, 0, 0,  0,   0,   0);

      foreach (directed_plan[k])
         send_request(directed_plan[k].q, directed_plan[k].typed, directed_plan[k].want,
                      predicted);
      req_tvalid <= 1'b0;

      for (int phase = 1; phase <= 3; phase++) begin
         wait_drained();
         case (phase)
            1: set_start_cell(4'd15, 4'd15);
            2: set_start_cell(4'd0, 4'd15);
            default: set_start_cell(4'd15, 4'd0);
         endcase
         send_idle_pct = (phase == 1) ? 20 : (phase == 2) ? 80 : 0;
         recv_idle_pct = (phase == 1) ? 80 : (phase == 2) ? 20 : 0;
         hold_asks++;
         run_flood_traffic(RANDOM_PER_PHASE);
         req_tvalid <= 1'b0;
      end

      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("maze_flood_map_engine verification clean");
      end else begin
         $display("maze_flood_map_engine verification failed");
      end
      $finish;
   end

endmodule
